// ===== rtl/fhf_pkg.sv =====
// Shared types, constants and helpers of the fire heat field update block.
package fhf_pkg;

  // configuration port
  localparam int unsigned CFG_INDEX_W = 4;
  localparam int unsigned CFG_DATA_W  = 9;

  localparam logic [CFG_INDEX_W-1:0] REG_GRID_WIDTH  = 4'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_GRID_HEIGHT = 4'd1;

  // grid size handling
  localparam int unsigned SIZE_CALC_W = 13;
  localparam int unsigned SIZE_MIN    = 2;
  localparam logic [CFG_DATA_W-1:0] SIZE_RESET = 9'd256;

  // 1/4.025 as an unsigned Q0.16 factor
  localparam int unsigned DIV_FACTOR_W = 14;
  localparam logic [DIV_FACTOR_W-1:0] DIV_FACTOR = 14'd16283;
  localparam int unsigned DIV_SHIFT = 16;

  // stream payload widths
  localparam int unsigned SEED_W      = 17;
  localparam int unsigned HEAT_OUT_W  = 17;
  localparam int unsigned POS_OUT_W   = 8;
  localparam int unsigned IN_TDATA_W  = 24;
  localparam int unsigned OUT_TDATA_W = 40;
  localparam int unsigned OUT_PAD_W   = OUT_TDATA_W - HEAT_OUT_W - 2 * POS_OUT_W;
  localparam int unsigned COL_LSB     = HEAT_OUT_W;
  localparam int unsigned ROW_LSB     = HEAT_OUT_W + POS_OUT_W;

  typedef struct packed {
    logic is_seed;
    logic frame_end;
  } item_flags_t;

  // limit a written size to the range 2..max
  function automatic logic [SIZE_CALC_W-1:0] clamp_size(logic [CFG_DATA_W-1:0] v,
                                                        int unsigned max);
    logic [SIZE_CALC_W-1:0] ve;
    logic [SIZE_CALC_W-1:0] res;
    ve = SIZE_CALC_W'(v);
    if (ve < SIZE_CALC_W'(SIZE_MIN)) begin
      res = SIZE_CALC_W'(SIZE_MIN);
    end else if (ve > SIZE_CALC_W'(max)) begin
      res = SIZE_CALC_W'(max);
    end else begin
      res = ve;
    end
    return res;
  endfunction

endpackage

// ===== rtl/fire_heat_field_update.sv =====
// Fire heat field update: top level with stream ports and configuration port.
// Throughput: one word per cycle while m_axis_tready is high; an update waits in the address stage while one of the
// three words ahead of it still has to write a cell it reads (grids two rows tall, or
// three rows tall and at most three columns wide).
// Reset: scan restarts at seeding, sizes return to 256 (clamped to the maximum), and the
// heat store is zeroed by a sweep over all 2**(clog2(MAX_WIDTH)+clog2(MAX_HEIGHT)) cells
// (65536 at default size) with s_axis_tready low; configuration writes are taken meanwhile.
module fire_heat_field_update #(
  parameter int unsigned MAX_WIDTH  = 256,
  parameter int unsigned MAX_HEIGHT = 256,
  parameter int unsigned HEAT_BITS  = 17
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  input  logic [fhf_pkg::IN_TDATA_W-1:0]       s_axis_tdata,  // seed_heat[16:0]
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  output logic [fhf_pkg::OUT_TDATA_W-1:0]      m_axis_tdata,  // heat[16:0], column[24:17], row[32:25]
  output logic                                 m_axis_tuser,  // is_seed
  output logic                                 m_axis_tlast,  // frame_end
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [fhf_pkg::CFG_INDEX_W-1:0]      cfg_index_i,
  input  logic [fhf_pkg::CFG_DATA_W-1:0]       cfg_data_i
);

  localparam int unsigned XB = $clog2(MAX_WIDTH);
  localparam int unsigned YB = $clog2(MAX_HEIGHT);
  localparam int unsigned AW = XB + YB;

  logic [3:0][AW-1:0]   rd_addr;
  logic [AW-1:0]        wr_addr;
  fhf_pkg::item_flags_t flags;
  logic                 clear_busy;
  logic [AW-1:0]        clear_addr;
  logic                 pipe_ready;
  logic                 in_accept;
  logic [HEAT_BITS-1:0] seed;
  logic [HEAT_BITS-1:0] out_heat;
  logic [AW-1:0]        out_addr;
  fhf_pkg::item_flags_t out_flags;

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = pipe_ready && !clear_busy;
  assign in_accept     = s_axis_tvalid && s_axis_tready;
  assign seed          = HEAT_BITS'(s_axis_tdata[fhf_pkg::SEED_W-1:0]);

  fhf_scan #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_scan (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_valid_i && cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .accept_i     (in_accept),
    .rd_addr_o    (rd_addr),
    .wr_addr_o    (wr_addr),
    .flags_o      (flags),
    .clear_busy_o (clear_busy),
    .clear_addr_o (clear_addr)
  );

  fhf_pipe #(
    .XB (XB),
    .YB (YB),
    .HB (HEAT_BITS)
  ) u_pipe (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid && !clear_busy),
    .in_ready_o   (pipe_ready),
    .seed_i       (seed),
    .rd_addr_i    (rd_addr),
    .wr_addr_i    (wr_addr),
    .flags_i      (flags),
    .clear_busy_i (clear_busy),
    .clear_addr_i (clear_addr),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_heat_o   (out_heat),
    .out_addr_o   (out_addr),
    .out_flags_o  (out_flags)
  );

  assign m_axis_tdata = {{fhf_pkg::OUT_PAD_W{1'b0}},
                         fhf_pkg::POS_OUT_W'(out_addr[AW-1:XB]),
                         fhf_pkg::POS_OUT_W'(out_addr[XB-1:0]),
                         fhf_pkg::HEAT_OUT_W'(out_heat)};
  assign m_axis_tuser = out_flags.is_seed;
  assign m_axis_tlast = out_flags.frame_end;

endmodule

// ===== rtl/fhf_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module fhf_ram #(
  parameter int unsigned WIDTH = 17,
  parameter int unsigned DEPTH = 65536
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/fhf_scan.sv =====
// Grid size registers, raster scan counters, cell address generation and reset clear sweep.
module fhf_scan #(
  parameter int unsigned MAX_WIDTH  = 256,
  parameter int unsigned MAX_HEIGHT = 256,
  localparam int unsigned XB = $clog2(MAX_WIDTH),
  localparam int unsigned YB = $clog2(MAX_HEIGHT),
  localparam int unsigned AW = XB + YB
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [fhf_pkg::CFG_INDEX_W-1:0]    cfg_index_i,
  input  logic [fhf_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  input  logic                               accept_i,
  output logic [3:0][AW-1:0]                 rd_addr_o,
  output logic [AW-1:0]                      wr_addr_o,
  output fhf_pkg::item_flags_t               flags_o,
  output logic                               clear_busy_o,
  output logic [AW-1:0]                      clear_addr_o
);

  localparam int unsigned WW = $clog2(MAX_WIDTH + 1);
  localparam int unsigned HW = $clog2(MAX_HEIGHT + 1);
  localparam logic [WW-1:0] W_RST = WW'(fhf_pkg::clamp_size(fhf_pkg::SIZE_RESET, MAX_WIDTH));
  localparam logic [HW-1:0] H_RST = HW'(fhf_pkg::clamp_size(fhf_pkg::SIZE_RESET, MAX_HEIGHT));

  logic [WW-1:0] width_q, width_d;
  logic [HW-1:0] height_q, height_d;
  logic [XB-1:0] col_q, col_d;
  logic [YB-1:0] row_q, row_d;
  logic          seeding_q, seeding_d;
  logic          clr_busy_q, clr_busy_d;
  logic [AW-1:0] clr_addr_q, clr_addr_d;

  logic [WW-1:0] col_nxt;
  logic [HW-1:0] row_nxt, row_nxt2, h_m1;
  logic          col_last, row_last;
  logic [XB-1:0] xl, xr;
  logic [YB-1:0] y1, y2, y_cell;

  always_comb begin
    col_nxt  = WW'(col_q) + WW'(1);
    row_nxt  = HW'(row_q) + HW'(1);
    row_nxt2 = HW'(row_q) + HW'(2);
    h_m1     = height_q - HW'(1);
    col_last = col_nxt >= width_q;
    row_last = row_nxt2 >= height_q;
    xl       = (col_q == '0) ? XB'(width_q - WW'(1)) : col_q - XB'(1);
    xr       = col_last ? '0 : XB'(col_nxt);
    // update rows never pass h-2, so only the second row down can wrap
    y1       = YB'(row_nxt);
    y2       = row_last ? '0 : YB'(row_nxt2);
    y_cell   = seeding_q ? YB'(h_m1) : row_q;
  end

  assign rd_addr_o[0] = {y1, xl};
  assign rd_addr_o[1] = {y1, col_q};
  assign rd_addr_o[2] = {y1, xr};
  assign rd_addr_o[3] = {y2, col_q};
  assign wr_addr_o    = {y_cell, col_q};
  assign flags_o.is_seed   = seeding_q;
  assign flags_o.frame_end = !seeding_q && col_last && row_last;

  always_comb begin
    width_d   = width_q;
    height_d  = height_q;
    col_d     = col_q;
    row_d     = row_q;
    seeding_d = seeding_q;
    if (cfg_we_i && (cfg_index_i == fhf_pkg::REG_GRID_WIDTH ||
                     cfg_index_i == fhf_pkg::REG_GRID_HEIGHT)) begin
      if (cfg_index_i == fhf_pkg::REG_GRID_WIDTH) begin
        width_d = WW'(fhf_pkg::clamp_size(cfg_data_i, MAX_WIDTH));
      end else begin
        height_d = HW'(fhf_pkg::clamp_size(cfg_data_i, MAX_HEIGHT));
      end
      col_d     = '0;
      row_d     = '0;
      seeding_d = 1'b1;
    end else if (accept_i) begin
      if (col_last) begin
        col_d = '0;
        if (seeding_q) begin
          row_d     = '0;
          seeding_d = 1'b0;
        end else if (row_last) begin
          row_d     = '0;
          seeding_d = 1'b1;
        end else begin
          row_d = YB'(row_nxt);
        end
      end else begin
        col_d = XB'(col_nxt);
      end
    end
  end

  // zero sweep over the whole store after reset
  always_comb begin
    clr_busy_d = clr_busy_q;
    clr_addr_d = clr_addr_q;
    if (clr_busy_q) begin
      clr_addr_d = clr_addr_q + AW'(1);
      if (clr_addr_q == '1) begin
        clr_busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q    <= W_RST;
      height_q   <= H_RST;
      col_q      <= '0;
      row_q      <= '0;
      seeding_q  <= 1'b1;
      clr_busy_q <= 1'b1;
      clr_addr_q <= '0;
    end else begin
      width_q    <= width_d;
      height_q   <= height_d;
      col_q      <= col_d;
      row_q      <= row_d;
      seeding_q  <= seeding_d;
      clr_busy_q <= clr_busy_d;
      clr_addr_q <= clr_addr_d;
    end
  end

  assign clear_busy_o = clr_busy_q;
  assign clear_addr_o = clr_addr_q;

endmodule

// ===== rtl/fhf_pipe.sv =====
// Heat update pipeline: neighbor reads, sum, scale multiply, output register and store write.
module fhf_pipe #(
  parameter int unsigned XB = 8,
  parameter int unsigned YB = 8,
  parameter int unsigned HB = 17,
  localparam int unsigned AW = XB + YB
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [HB-1:0]        seed_i,
  input  logic [3:0][AW-1:0]   rd_addr_i,
  input  logic [AW-1:0]        wr_addr_i,
  input  fhf_pkg::item_flags_t flags_i,
  input  logic                 clear_busy_i,
  input  logic [AW-1:0]        clear_addr_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [HB-1:0]        out_heat_o,
  output logic [AW-1:0]        out_addr_o,
  output fhf_pkg::item_flags_t out_flags_o
);

  localparam int unsigned SW = HB + 2;
  localparam int unsigned PW = SW + fhf_pkg::DIV_FACTOR_W;

  // stage A: addresses
  logic                 a_valid_q, a_valid_d;
  logic [3:0][AW-1:0]   a_rd_q;
  logic [AW-1:0]        a_wr_q;
  fhf_pkg::item_flags_t a_flags_q;
  logic [HB-1:0]        a_seed_q;
  // stage B: store data
  logic                 b_valid_q, b_valid_d;
  logic [AW-1:0]        b_wr_q;
  fhf_pkg::item_flags_t b_flags_q;
  logic [HB-1:0]        b_seed_q;
  logic [3:0][HB-1:0]   rd_data;
  // stage C: sum
  logic                 c_valid_q, c_valid_d;
  logic [SW-1:0]        c_sum_q;
  logic [AW-1:0]        c_wr_q;
  fhf_pkg::item_flags_t c_flags_q;
  logic [HB-1:0]        c_seed_q;
  // stage D: product
  logic                 d_valid_q, d_valid_d;
  logic [PW-1:0]        d_prod_q;
  logic [AW-1:0]        d_wr_q;
  fhf_pkg::item_flags_t d_flags_q;
  logic [HB-1:0]        d_seed_q;
  logic [HB-1:0]        d_heat;
  // output register
  logic                 o_valid_q, o_valid_d;
  logic [HB-1:0]        o_heat_q;
  logic [AW-1:0]        o_wr_q;
  fhf_pkg::item_flags_t o_flags_q;

  logic o_rdy, d_rdy, c_rdy, b_rdy, a_rdy;
  logic d_adv, c_adv, b_adv, a_adv, in_fire;
  logic hazard;
  logic ram_we;
  logic [AW-1:0] ram_waddr;
  logic [HB-1:0] ram_wdata;

  assign o_rdy = !o_valid_q || out_ready_i;
  assign d_rdy = !d_valid_q || o_rdy;
  assign c_rdy = !c_valid_q || d_rdy;
  assign b_rdy = !b_valid_q || c_rdy;
  assign d_adv = d_valid_q && o_rdy;
  assign c_adv = c_valid_q && d_rdy;
  assign b_adv = b_valid_q && c_rdy;

  // hold an update in A while a cell it reads still has a write in flight
  always_comb begin
    hazard = 1'b0;
    for (int k = 0; k < 4; k++) begin
      if ((b_valid_q && a_rd_q[k] == b_wr_q) ||
          (c_valid_q && a_rd_q[k] == c_wr_q) ||
          (d_valid_q && a_rd_q[k] == d_wr_q)) begin
        hazard = 1'b1;
      end
    end
    hazard = hazard && a_valid_q && !a_flags_q.is_seed;
  end

  assign a_adv      = a_valid_q && !hazard && b_rdy;
  assign a_rdy      = !a_valid_q || a_adv;
  assign in_ready_o = a_rdy;
  assign in_fire    = in_valid_i && a_rdy;

  always_comb begin
    a_valid_d = a_valid_q;
    if (in_fire) begin
      a_valid_d = 1'b1;
    end else if (a_adv) begin
      a_valid_d = 1'b0;
    end
    b_valid_d = b_rdy ? a_adv     : b_valid_q;
    c_valid_d = c_rdy ? b_valid_q : c_valid_q;
    d_valid_d = d_rdy ? c_valid_q : d_valid_q;
    o_valid_d = o_rdy ? d_valid_q : o_valid_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      b_valid_q <= 1'b0;
      c_valid_q <= 1'b0;
      d_valid_q <= 1'b0;
      o_valid_q <= 1'b0;
    end else begin
      a_valid_q <= a_valid_d;
      b_valid_q <= b_valid_d;
      c_valid_q <= c_valid_d;
      d_valid_q <= d_valid_d;
      o_valid_q <= o_valid_d;
    end
  end

  assign d_heat = d_flags_q.is_seed ? d_seed_q : d_prod_q[fhf_pkg::DIV_SHIFT +: HB];

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      a_rd_q    <= rd_addr_i;
      a_wr_q    <= wr_addr_i;
      a_flags_q <= flags_i;
      a_seed_q  <= seed_i;
    end
    if (a_adv) begin
      b_wr_q    <= a_wr_q;
      b_flags_q <= a_flags_q;
      b_seed_q  <= a_seed_q;
    end
    if (b_adv) begin
      c_sum_q   <= SW'(rd_data[0]) + SW'(rd_data[1]) + SW'(rd_data[2]) + SW'(rd_data[3]);
      c_wr_q    <= b_wr_q;
      c_flags_q <= b_flags_q;
      c_seed_q  <= b_seed_q;
    end
    if (c_adv) begin
      d_prod_q  <= PW'(c_sum_q) * PW'(fhf_pkg::DIV_FACTOR);
      d_wr_q    <= c_wr_q;
      d_flags_q <= c_flags_q;
      d_seed_q  <= c_seed_q;
    end
    if (d_adv) begin
      o_heat_q  <= d_heat;
      o_wr_q    <= d_wr_q;
      o_flags_q <= d_flags_q;
    end
  end

  // the cell lands in the store as its word enters the output register
  assign ram_we    = clear_busy_i || d_adv;
  assign ram_waddr = clear_busy_i ? clear_addr_i : d_wr_q;
  assign ram_wdata = clear_busy_i ? '0 : d_heat;

  // one copy of the store per neighbor read
  for (genvar k = 0; k < 4; k++) begin : g_store
    fhf_ram #(
      .WIDTH (HB),
      .DEPTH (2 ** AW)
    ) u_store (
      .clk_i   (clk_i),
      .we_i    (ram_we),
      .waddr_i (ram_waddr),
      .wdata_i (ram_wdata),
      .re_i    (a_adv),
      .raddr_i (a_rd_q[k]),
      .rdata_o (rd_data[k])
    );
  end

  assign out_valid_o = o_valid_q;
  assign out_heat_o  = o_heat_q;
  assign out_addr_o  = o_wr_q;
  assign out_flags_o = o_flags_q;

endmodule

// ===== rtl/fhf_checker.sv =====
// Port-level assertions for the fire heat field update, bound to the top level.
module fhf_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            m_axis_tvalid,
  input logic                            m_axis_tready,
  input logic [fhf_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
  input logic                            m_axis_tuser,
  input logic                            m_axis_tlast
);

  // high until the first output word, and again after each frame end
  logic after_last_q, after_last_d;

  always_comb begin
    after_last_d = after_last_q;
    if (m_axis_tvalid && m_axis_tready) begin
      after_last_d = m_axis_tlast;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      after_last_q <= 1'b1;
    end else begin
      after_last_q <= after_last_d;
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) && $stable(m_axis_tlast))
    else $error("output word changed while stalled");

  a_seed_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |-> !m_axis_tlast)
    else $error("seed word marked as frame end");

  a_frame_starts_seeding: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && after_last_q |->
      m_axis_tuser &&
      m_axis_tdata[fhf_pkg::COL_LSB +: fhf_pkg::POS_OUT_W] == '0)
    else $error("frame does not start with a seed word at column 0");

endmodule

bind fire_heat_field_update fhf_checker u_fhf_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast)
);
